// ===== sv/dcfd_pkg.sv =====
// ============================================================================
// dcfd_pkg: shared types and constants for the digit crossfade frame driver
// Digit codes, fade phases, register indexes, segment table and time helpers.
// ============================================================================
package dcfd_pkg;

    localparam int NDIG       = 6;
    localparam int IDX_W      = 3;
    localparam int SEG_W      = 8;
    localparam int LEVEL_W    = 4;
    localparam int DIM_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd15;
    localparam logic [SEG_W-1:0]   SEG_MASK  = 8'hFE;
    localparam logic [SEG_W-1:0]   DOT_MASK  = 8'h01;
    localparam logic [IDX_W-1:0]   LAST_DIG  = 3'(NDIG - 1);

    // Word kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_TIME = 2'd1;
    localparam logic [1:0] KIND_RAW  = 2'd2;

    // Fade modes
    localparam logic [1:0] FADE_NONE  = 2'd0;
    localparam logic [1:0] FADE_BLEND = 2'd2;

    // Time formats
    localparam logic [1:0] FMT_24H    = 2'd0;
    localparam logic [1:0] FMT_12H_NZ = 2'd2;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SHIFT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_MODE = 1'd1;

    typedef enum logic [1:0] {
        PH_NONE   = 2'd0,
        PH_OUT    = 2'd1,
        PH_SWITCH = 2'd2,
        PH_IN     = 2'd3
    } t_phase;

    // Control broadcast from the sequencer to every digit cell
    typedef struct packed {
        logic               tick;       // load byte, step fades
        logic               advance;    // fades step on this tick
        logic               blank;      // dimmer blanks this frame
        logic               shift;      // move bytes one cell toward digit 0
        logic               time_load;  // new time target
        logic [1:0]         fade_mode;
        logic [LEVEL_W-1:0] pwm_step;
    } t_cell_ctl;

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'hFC;
            4'd1:    s = 8'h60;
            4'd2:    s = 8'hDA;
            4'd3:    s = 8'hF2;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'hB6;
            4'd6:    s = 8'hBE;
            4'd7:    s = 8'hE0;
            4'd8:    s = 8'hFE;
            4'd9:    s = 8'hF6;
            default: s = 8'hFC;
        endcase
        return s;
    endfunction

    // Tens digit of a value below 64
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [6:0] tx10;
        logic [6:0] u;
        tx10 = 7'(tens_of(v)) * 7'd10;
        u    = {1'b0, v} - tx10;
        return u[3:0];
    endfunction

endpackage

// ===== sv/dcfd_in_if.sv =====
// ============================================================================
// dcfd_in_if: input word channel
// Valid/ready channel carrying one tick, time or raw digit word.
// ============================================================================
interface dcfd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [5:0] dot_mask;
    logic [1:0] time_format;
    logic [2:0] digit_sel;
    logic [7:0] raw_pattern;

    modport source (
        output valid, kind, hours, minutes, seconds, dot_mask, time_format,
               digit_sel, raw_pattern,
        input  ready
    );
    modport sink (
        input  valid, kind, hours, minutes, seconds, dot_mask, time_format,
               digit_sel, raw_pattern,
        output ready
    );
endinterface

// ===== sv/dcfd_out_if.sv =====
// ============================================================================
// dcfd_out_if: digit byte channel
// Valid/ready channel carrying one digit byte of a frame.
// ============================================================================
interface dcfd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] digit_index;
    logic [7:0] segments;
    logic       frame_end;

    modport source (
        output valid, digit_index, segments, frame_end,
        input  ready
    );
    modport sink (
        input  valid, digit_index, segments, frame_end,
        output ready
    );
endinterface

// ===== sv/dcfd_cell.sv =====
// ============================================================================
// dcfd_cell: one digit cell
// Holds one digit's pattern and fade state, renders its byte on a tick and
// passes bytes toward digit 0 along the chain.
// ============================================================================
module dcfd_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dcfd_pkg::t_cell_ctl         i_ctl,
    input  logic                        i_raw_we,
    input  logic [dcfd_pkg::SEG_W-1:0]  i_raw,
    input  logic [dcfd_pkg::SEG_W-1:0]  i_target,
    input  logic [dcfd_pkg::SEG_W-1:0]  i_byte_next,
    output logic [dcfd_pkg::SEG_W-1:0]  o_byte
);
    import dcfd_pkg::*;

    logic [SEG_W-1:0]   r_shown, n_shown;
    t_phase             r_phase, n_phase;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [SEG_W-1:0]   r_out,   n_out;
    logic [SEG_W-1:0]   r_in,    n_in;
    logic [SEG_W-1:0]   r_byte,  n_byte;

    t_phase             ph_a;
    logic [LEVEL_W-1:0] lv_a;
    logic [SEG_W-1:0]   dark;
    logic [SEG_W-1:0]   fade_src;
    logic [SEG_W-1:0]   rendered;

    // Fade step, applied only on the first PWM phase
    always_comb begin
        ph_a = r_phase;
        lv_a = r_level;
        if (i_ctl.advance) begin
            case (r_phase)
                PH_OUT: begin
                    lv_a = (r_level != '0) ? r_level - 1'b1 : '0;
                    if (r_level == '0) ph_a = PH_SWITCH;
                end
                PH_SWITCH: begin
                    ph_a = PH_IN;
                    lv_a = '0;
                end
                PH_IN: begin
                    lv_a = (r_level != LEVEL_MAX) ? r_level + 1'b1 : LEVEL_MAX;
                    if (r_level == LEVEL_MAX) ph_a = PH_NONE;
                end
                default: ;
            endcase
        end
    end

    // Byte shown this frame
    always_comb begin
        dark     = (i_ctl.fade_mode == FADE_BLEND) ? (r_in & r_out)
                                                   : (r_shown & DOT_MASK);
        fade_src = (ph_a == PH_OUT) ? r_out : r_in;
        case (ph_a)
            PH_OUT, PH_IN: begin
                rendered = (i_ctl.pwm_step < lv_a)
                         ? ((fade_src & SEG_MASK) | (r_shown & DOT_MASK)) : dark;
            end
            PH_SWITCH: rendered = dark;
            default:   rendered = r_shown;
        endcase
    end

    always_comb begin
        n_shown = r_shown;
        n_phase = r_phase;
        n_level = r_level;
        n_out   = r_out;
        n_in    = r_in;
        n_byte  = r_byte;
        if (i_ctl.tick) begin
            n_phase = ph_a;
            n_level = lv_a;
            n_byte  = i_ctl.blank ? '0 : rendered;
        end else if (i_ctl.shift) begin
            n_byte  = i_byte_next;
        end
        if (i_ctl.time_load) begin
            if ((r_shown & SEG_MASK) != (i_target & SEG_MASK)) begin
                if (i_ctl.fade_mode == FADE_NONE) begin
                    n_phase = PH_NONE;
                end else begin
                    n_phase = PH_OUT;
                    n_out   = r_shown;
                    n_in    = i_target;
                    n_level = LEVEL_MAX;
                end
            end else begin
                n_in = i_target;
            end
            n_shown = i_target;
        end
        if (i_raw_we) n_shown = i_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown <= '0;
            r_phase <= PH_NONE;
            r_level <= '0;
            r_out   <= '0;
            r_in    <= '0;
        end else begin
            r_shown <= n_shown;
            r_phase <= n_phase;
            r_level <= n_level;
            r_out   <= n_out;
            r_in    <= n_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

// ===== sv/digit_crossfade_frame_driver.sv =====
// A tick word puts digit 0 on the output in the cycle after it is taken;
// the six bytes then leave one per cycle while the sink is ready, from the
// head of the cell chain. No new word is taken until the last byte is taken.
// Time and raw words give no bytes.
// Reset (synchronous, active low) clears the digit, fade, PWM and dimmer state
// and the config registers, but not the cell output bytes; no clearing pass is needed.
// ============================================================================
// digit_crossfade_frame_driver: six-digit seven-segment crossfade driver
// Six digit cells in a row hold the display state; a frame tick renders all
// six bytes at once and shifts them out toward digit 0, one per cycle while the sink is ready.
// ============================================================================
module digit_crossfade_frame_driver (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dcfd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dcfd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    dcfd_in_if.sink                           i_in,
    dcfd_out_if.source                        o_out
);
    import dcfd_pkg::*;

    // Config registers
    logic [2:0]         r_dim_shift;
    logic [1:0]         r_fade_mode;

    // Frame timing: PWM phase and dimmer counter
    logic [LEVEL_W-1:0] r_pwm_step, n_pwm_step;
    logic [DIM_W-1:0]   r_dim_count, n_dim_count;
    logic [DIM_W-1:0]   dim_inc;

    // Shift-out sequencer: busy while a frame's bytes are leaving
    logic               r_busy, n_busy;
    logic [IDX_W-1:0]   r_idx, n_idx;

    logic               in_take;
    logic               out_take;
    logic               is_tick;
    logic               is_time;
    logic               is_raw;
    t_cell_ctl          ctl;

    // Time decode
    logic [4:0]         hr;
    logic [SEG_W-1:0]   target [NDIG];
    logic [SEG_W-1:0]   chain  [NDIG+1];

    assign i_in.ready = !r_busy;
    assign in_take    = i_in.valid && i_in.ready;
    assign out_take   = o_out.valid && o_out.ready;
    assign is_tick    = in_take && (i_in.kind == KIND_TICK);
    assign is_time    = in_take && (i_in.kind == KIND_TIME);
    assign is_raw     = in_take && (i_in.kind == KIND_RAW);

    // Twelve-hour fold works on the raw 5-bit hours
    always_comb begin
        hr = i_in.hours;
        if (i_in.time_format != FMT_24H) begin
            if (i_in.hours > 5'd12)       hr = i_in.hours - 5'd12;
            else if (i_in.hours == 5'd0)  hr = 5'd12;
        end
    end

    always_comb begin
        target[0] = seg_of(units_of(i_in.seconds));
        target[1] = seg_of(tens_of(i_in.seconds));
        target[2] = seg_of(units_of(i_in.minutes));
        target[3] = seg_of(tens_of(i_in.minutes));
        target[4] = seg_of(units_of({1'b0, hr}));
        target[5] = seg_of(tens_of({1'b0, hr}));
        for (int k = 0; k < NDIG; k++) begin
            target[k] = target[k] | {7'd0, i_in.dot_mask[k]};
        end
        // Leading hour zero dropped for hours 13 to 21 in FMT_12H_NZ, dot kept
        if (i_in.time_format == FMT_12H_NZ && i_in.hours > 5'd12 && i_in.hours < 5'd22)
            target[5] = target[5] & DOT_MASK;
    end

    always_comb begin
        ctl.tick      = is_tick;
        ctl.advance   = (r_pwm_step == '0);
        ctl.blank     = (r_dim_count != '0);
        ctl.shift     = out_take;
        ctl.time_load = is_time;
        ctl.fade_mode = r_fade_mode;
        ctl.pwm_step  = r_pwm_step;
    end

    assign chain[NDIG] = '0;

    for (genvar g = 0; g < NDIG; g++) begin : g_cell
        dcfd_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_raw_we    (is_raw && (i_in.digit_sel == IDX_W'(g))),
            .i_raw       (i_in.raw_pattern),
            .i_target    (target[g]),
            .i_byte_next (chain[g+1]),
            .o_byte      (chain[g])
        );
    end

    // PWM and dimmer advance after each tick; a dim-shift write clears the dimmer
    always_comb begin
        n_pwm_step  = r_pwm_step;
        n_dim_count = r_dim_count;
        dim_inc     = r_dim_count + 1'b1;
        if (is_tick) begin
            n_pwm_step  = r_pwm_step + 1'b1;
            n_dim_count = (dim_inc == (DIM_W'(1) << r_dim_shift)) ? '0 : dim_inc;
        end
        if (i_cfg_we && i_cfg_idx == REG_DIM_SHIFT) n_dim_count = '0;
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (is_tick) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (out_take) begin
            if (r_idx == LAST_DIG) n_busy = 1'b0;
            else                   n_idx  = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_shift <= '0;
            r_fade_mode <= '0;
            r_pwm_step  <= '0;
            r_dim_count <= '0;
            r_busy      <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_DIM_SHIFT: r_dim_shift <= i_cfg_data;
                    REG_FADE_MODE: r_fade_mode <= i_cfg_data[1:0];
                endcase
            end
            r_pwm_step  <= n_pwm_step;
            r_dim_count <= n_dim_count;
            r_busy      <= n_busy;
            r_idx       <= n_idx;
        end
    end

    assign o_out.valid       = r_busy;
    assign o_out.digit_index = r_idx;
    assign o_out.segments    = chain[0];
    assign o_out.frame_end   = (r_idx == LAST_DIG);

`ifndef NO_ASSERTIONS
    // No new word is taken while a frame is being shifted out
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while frame bytes pending");

    // A tick starts a frame at digit 0
    a_tick_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.kind == KIND_TICK)
        |=> (o_out.valid && o_out.digit_index == '0))
        else $error("tick did not start a frame at digit 0");

    // Frame ends after its last byte is taken
    a_frame_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.frame_end) |=> !o_out.valid)
        else $error("bytes continue past frame end");

    // Non-final bytes advance the digit index by one
    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.frame_end)
        |=> (o_out.valid && o_out.digit_index == $past(o_out.digit_index) + 3'd1))
        else $error("digit index skipped");
`endif

endmodule
